>>> hw/rtl/tcfwa_pkg.sv
// Shared types, constants and helper functions of the two-class FIFO arbiter.
`default_nettype none

package tcfwa_pkg;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned PTR_SPAN    = 2 * QUEUE_DEPTH;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned PTR_W       = $clog2(PTR_SPAN);

  localparam int unsigned ID_W        = 16;
  localparam int unsigned AGE_W       = 8;
  localparam int unsigned ENTRY_W     = ID_W + AGE_W;
  localparam int unsigned STREAK_W    = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [AGE_W-1:0]    AGE_THRESHOLD_RESET = AGE_W'(60);
  localparam logic [STREAK_W-1:0] STREAK_LIMIT_RESET  = '0;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(PTR_SPAN - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(QUEUE_DEPTH);

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Request kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  // Queue classes
  localparam logic CLASS_ORDINARY = 1'b0;
  localparam logic CLASS_PRIORITY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STREAK_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AGE_THRESHOLD = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    STATUS_ADDED   = 2'd0,
    STATUS_SERVED  = 2'd1,
    STATUS_NOTHING = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // One memory's access for the current request
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
  } mem_req_t;

  // Outcome of the current request as decided by the pointer logic
  typedef struct packed {
    status_t status;
    logic    served_class;
  } decision_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t ptr_index(input ptr_t p);
    ptr_t r;
    if (p >= PTR_DEPTH) begin
      r = p - PTR_DEPTH;
    end else begin
      r = p;
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic ptr_full(input ptr_t head, input ptr_t tail);
    ptr_t span;
    if (tail >= head) begin
      span = tail - head;
    end else begin
      span = head - tail;
    end
    return span == PTR_DEPTH;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcfwa_if.sv
// Request, response and configuration channel interfaces of the arbiter.
`default_nettype none

interface tcfwa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [tcfwa_pkg::ID_W-1:0]     person_id;
  logic [tcfwa_pkg::AGE_W-1:0]    age;

  modport source (output valid, kind, person_id, age, input ready);
  modport sink   (input valid, kind, person_id, age, output ready);
endinterface

interface tcfwa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [tcfwa_pkg::ID_W-1:0]     served_id;
  logic [tcfwa_pkg::AGE_W-1:0]    served_age;
  logic                           served_class;

  modport source (output valid, status, served_id, served_age, served_class, input ready);
  modport sink   (input valid, status, served_id, served_age, served_class, output ready);
endinterface

interface tcfwa_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tcfwa_pkg::CFG_IDX_W-1:0]    index;
  logic [tcfwa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tcfwa_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module tcfwa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcfwa_ctrl.sv
// Ring pointers, streak counter, configuration registers and request decision.
`default_nettype none

module tcfwa_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  tcfwa_cfg_if.sink                         cfg,
  input  wire logic                         accept,
  input  wire logic                         kind,
  input  wire logic [tcfwa_pkg::ID_W-1:0]   person_id,
  input  wire logic [tcfwa_pkg::AGE_W-1:0]  age,
  output tcfwa_pkg::mem_req_t               prio_mem,
  output tcfwa_pkg::mem_req_t               ord_mem,
  output tcfwa_pkg::decision_t              dec
);
  import tcfwa_pkg::*;

  ptr_t                 prio_head, prio_tail, ord_head, ord_tail;
  ptr_t                 prio_head_next, prio_tail_next, ord_head_next, ord_tail_next;
  logic [STREAK_W-1:0]  streak, streak_next;
  logic [STREAK_W-1:0]  streak_limit;
  logic [AGE_W-1:0]     age_threshold;

  logic prio_empty, ord_empty, prio_full, ord_full;
  logic to_prio, add_ok;
  entry_t add_entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      streak_limit  <= STREAK_LIMIT_RESET;
      age_threshold <= AGE_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STREAK_LIMIT:  streak_limit  <= cfg.data;
        REG_AGE_THRESHOLD: age_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  assign prio_empty = (prio_head == prio_tail);
  assign ord_empty  = (ord_head == ord_tail);
  assign prio_full  = ptr_full(prio_head, prio_tail);
  assign ord_full   = ptr_full(ord_head, ord_tail);
  assign to_prio    = (age > age_threshold);
  assign add_ok     = to_prio ? !prio_full : !ord_full;
  assign add_entry  = {age, person_id};

  always_comb begin
    prio_head_next = prio_head;
    prio_tail_next = prio_tail;
    ord_head_next  = ord_head;
    ord_tail_next  = ord_tail;
    streak_next    = streak;
    dec            = '{status: STATUS_NOTHING, served_class: CLASS_ORDINARY};
    prio_mem       = '{wr_en: 1'b0, wr_addr: ptr_index(prio_tail), wr_data: add_entry,
                       rd_en: 1'b0, rd_addr: ptr_index(prio_head)};
    ord_mem        = '{wr_en: 1'b0, wr_addr: ptr_index(ord_tail), wr_data: add_entry,
                       rd_en: 1'b0, rd_addr: ptr_index(ord_head)};

    if (kind == KIND_ADD) begin
      dec.served_class = to_prio;
      dec.status       = add_ok ? STATUS_ADDED : STATUS_FULL;
      if (add_ok && to_prio) begin
        prio_mem.wr_en = accept;
        prio_tail_next = ptr_next(prio_tail);
      end else if (add_ok) begin
        ord_mem.wr_en = accept;
        ord_tail_next = ptr_next(ord_tail);
      end
    end else if (!(prio_empty && ord_empty)) begin
      dec.status = STATUS_SERVED;
      // Prefer priority while the streak differs from the limit; with ordinary empty, always
      if (!prio_empty && (ord_empty || streak != streak_limit)) begin
        dec.served_class = CLASS_PRIORITY;
        prio_mem.rd_en   = accept;
        prio_head_next   = ptr_next(prio_head);
        streak_next      = ord_empty ? '0 : streak + STREAK_W'(1);
      end else begin
        dec.served_class = CLASS_ORDINARY;
        ord_mem.rd_en    = accept;
        ord_head_next    = ptr_next(ord_head);
        streak_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_head <= '0;
      prio_tail <= '0;
      ord_head  <= '0;
      ord_tail  <= '0;
      streak    <= '0;
    end else if (accept) begin
      prio_head <= prio_head_next;
      prio_tail <= prio_tail_next;
      ord_head  <= ord_head_next;
      ord_tail  <= ord_tail_next;
      streak    <= streak_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/two_class_fifo_weighted_arbiter_core.sv
// Top level of the two-class FIFO arbiter with a starvation limit.
// Response: an add, or a serve with nothing queued, loads the output register
//   on acceptance; a serve that pops passes ST_READ for its memory read.
// Throughput: one add per cycle while the response side takes responses; no new
//   request is taken while a popping serve waits in ST_READ for its read data.
// Reset: pointers and streak clear, streak_limit to 0, age_threshold to 60;
//   entry memories are not cleared and there is no clearing pass.
`default_nettype none

module two_class_fifo_weighted_arbiter_core (
  input  wire logic   clk,
  input  wire logic   rst,
  tcfwa_req_if.sink   req,
  tcfwa_rsp_if.source rsp,
  tcfwa_cfg_if.sink   cfg
);
  import tcfwa_pkg::*;

  state_t    state, state_next;
  logic      accept;
  logic      load_now, load_mem;
  logic      read_class;
  mem_req_t  prio_mem, ord_mem;
  decision_t dec;
  entry_t    prio_rdata, ord_rdata, sel_rdata;

  // Output register, parts the response side from the request side
  logic                out_valid;
  status_t             out_status;
  logic [ID_W-1:0]     out_id;
  logic [AGE_W-1:0]    out_age;
  logic                out_class;

  // Take a request only when idle and the output slot is free or draining
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  tcfwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .kind      (req.kind),
    .person_id (req.person_id),
    .age       (req.age),
    .prio_mem  (prio_mem),
    .ord_mem   (ord_mem),
    .dec       (dec)
  );

  tcfwa_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_prio_ram (
    .clk     (clk),
    .wr_en   (prio_mem.wr_en),
    .wr_addr (prio_mem.wr_addr),
    .wr_data (prio_mem.wr_data),
    .rd_en   (prio_mem.rd_en),
    .rd_addr (prio_mem.rd_addr),
    .rd_data (prio_rdata)
  );

  tcfwa_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_ord_ram (
    .clk     (clk),
    .wr_en   (ord_mem.wr_en),
    .wr_addr (ord_mem.wr_addr),
    .wr_data (ord_mem.wr_data),
    .rd_en   (ord_mem.rd_en),
    .rd_addr (ord_mem.rd_addr),
    .rd_data (ord_rdata)
  );

  assign sel_rdata = (read_class == CLASS_PRIORITY) ? prio_rdata : ord_rdata;

  // Sequencer: a serve that pops waits in ST_READ for the memory read
  always_comb begin
    state_next = state;
    load_now   = 1'b0;
    load_mem   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_SERVE && dec.status == STATUS_SERVED) begin
            state_next = ST_READ;
          end else begin
            load_now = 1'b1;
          end
        end
      end
      ST_READ: begin
        load_mem   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Remember which memory the pending read came from
  always_ff @(posedge clk) begin
    if (accept) begin
      read_class <= dec.served_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_mem) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the response payload: immediate for adds and empty serves,
  // from the memory read data for a pop
  always_ff @(posedge clk) begin
    if (load_now) begin
      out_status <= dec.status;
      out_id     <= '0;
      out_age    <= '0;
      out_class  <= dec.served_class;
    end else if (load_mem) begin
      out_status <= STATUS_SERVED;
      out_id     <= sel_rdata[ID_W-1:0];
      out_age    <= sel_rdata[ENTRY_W-1:ID_W];
      out_class  <= read_class;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.served_id    = out_id;
  assign rsp.served_age   = out_age;
  assign rsp.served_class = out_class;

endmodule

`default_nettype wire

>>> tb/two_class_fifo_weighted_arbiter_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the two-class FIFO arbiter core with its own arbitration model.

module two_class_fifo_weighted_arbiter_core_test;
  import tcfwa_pkg::*;

  // Run ends here regardless of progress; several times the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } person_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic             cls;
  } outcome_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_REGISTER
  } row_op_t;

  // One line of the directed plan: a register write or a request, the latter
  // optionally with its response written out by hand.
  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    logic                  kind;
    logic [ID_W-1:0]       id;
    logic [AGE_W-1:0]      age;
    logic                  typed;
    outcome_t              want;
  } plan_row_t;

  localparam outcome_t NO_CHECK = '{STATUS_ADDED, 16'h0000, 8'h00, CLASS_ORDINARY};

  localparam int PLAN_ROWS = 26;

  // Directed opening: reset defaults, field extremes, the threshold edge, the
  // ordinary-first rule at a zero limit, empty serves, then a limit lowered
  // below a running streak.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // serve straight after reset: nothing queued
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'hffff, 8'hff, 1'b1,
      '{STATUS_NOTHING, 16'h0000, 8'h00, CLASS_ORDINARY}},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'h0000, 8'h00, 1'b1,
      '{STATUS_ADDED, 16'h0000, 8'h00, CLASS_ORDINARY}},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'hffff, 8'hff, 1'b1,
      '{STATUS_ADDED, 16'h0000, 8'h00, CLASS_PRIORITY}},
    // age equal to the threshold stays ordinary, one above goes priority
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'h1234, 8'd60, 1'b1,
      '{STATUS_ADDED, 16'h0000, 8'h00, CLASS_ORDINARY}},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'h4321, 8'd61, 1'b1,
      '{STATUS_ADDED, 16'h0000, 8'h00, CLASS_PRIORITY}},
    // limit 0 with both queues occupied: ordinary goes first
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h5a5a, 8'ha5, 1'b1,
      '{STATUS_SERVED, 16'h0000, 8'h00, CLASS_ORDINARY}},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'ha5a5, 8'h5a, 1'b1,
      '{STATUS_SERVED, 16'h1234, 8'd60, CLASS_ORDINARY}},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h0000, 8'h00, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'hffff, 8'hff, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h8001, 8'h81, 1'b1,
      '{STATUS_NOTHING, 16'h0000, 8'h00, CLASS_ORDINARY}},
    '{ROW_REGISTER, REG_STREAK_LIMIT, 8'd5, KIND_ADD, 16'h0000, 8'h00, 1'b0, NO_CHECK},
    '{ROW_REGISTER, REG_AGE_THRESHOLD, 8'd0, KIND_ADD, 16'h0000, 8'h00, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'ha001, 8'h01, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'ha002, 8'h80, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'ha003, 8'hff, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'ha004, 8'h02, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'ha005, 8'h7f, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'hb001, 8'h00, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_ADD, 16'hb002, 8'h00, 1'b0, NO_CHECK},
    // build a streak of three priority serves
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h0f0f, 8'h0f, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'hf0f0, 8'hf0, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h3c3c, 8'h3c, 1'b0, NO_CHECK},
    // drop the limit below the streak: priority keeps winning until its line runs out
    '{ROW_REGISTER, REG_STREAK_LIMIT, 8'd1, KIND_ADD, 16'h0000, 8'h00, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'hc3c3, 8'hc3, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h6969, 8'h69, 1'b0, NO_CHECK},
    '{ROW_REQUEST, REG_STREAK_LIMIT, 8'h00, KIND_SERVE, 16'h9696, 8'h96, 1'b0, NO_CHECK}
  };

  logic clk;
  logic rst;

  tcfwa_req_if req_ch ();
  tcfwa_rsp_if rsp_ch ();
  tcfwa_cfg_if cfg_ch ();

  two_class_fifo_weighted_arbiter_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Model state: both waiting lines, the streak and the two registers.
  person_t           priority_line [$];
  person_t           ordinary_line [$];
  logic [STREAK_W-1:0] streak;
  logic [STREAK_W-1:0] limit_reg;
  logic [AGE_W-1:0]    threshold_reg;

  outcome_t awaited_responses [$];
  int       mismatch_count;
  int       cycle_count;
  int       burst_left;
  int       hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest correct run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[two_class_fifo_weighted_arbiter_core] ERROR");
    $finish;
  end

  // Work out the response to one accepted request and advance the model.
  function automatic outcome_t arbitrate(input logic kind, input logic [ID_W-1:0] id,
                                         input logic [AGE_W-1:0] age);
    outcome_t o;
    person_t  p;
    logic     take_ordinary;
    o = NO_CHECK;
    if (kind == KIND_ADD) begin
      p.id  = id;
      p.age = age;
      if (age > threshold_reg) begin
        o.cls = CLASS_PRIORITY;
        if (priority_line.size() < QUEUE_DEPTH) priority_line.push_back(p);
        else o.status = STATUS_FULL;
      end else begin
        o.cls = CLASS_ORDINARY;
        if (ordinary_line.size() < QUEUE_DEPTH) ordinary_line.push_back(p);
        else o.status = STATUS_FULL;
      end
    end else if (priority_line.size() == 0 && ordinary_line.size() == 0) begin
      o.status = STATUS_NOTHING;
    end else begin
      o.status = STATUS_SERVED;
      // ordinary wins when priority is empty, or when the streak equals the limit
      take_ordinary = (priority_line.size() == 0) ||
                      (ordinary_line.size() != 0 && streak == limit_reg);
      if (take_ordinary) begin
        p      = ordinary_line.pop_front();
        o.cls  = CLASS_ORDINARY;
        streak = '0;
      end else begin
        p      = priority_line.pop_front();
        o.cls  = CLASS_PRIORITY;
        // a streak only builds while ordinary entries are left waiting; it wraps at 8 bits
        streak = (ordinary_line.size() == 0) ? '0 : streak + 8'd1;
      end
      o.id  = p.id;
      o.age = p.age;
    end
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h (cycle %0d)", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // Offer one request, in bursts with random gaps, and log its response once accepted.
  task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                              input logic [AGE_W-1:0] age, input logic typed = 1'b0,
                              input outcome_t want = NO_CHECK);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid     = 1'b1;
    req_ch.kind      = kind;
    req_ch.person_id = id;
    req_ch.age       = age;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (typed) begin
      // keep the model in step, but hold the block to the hand-written response
      void'(arbitrate(kind, id, age));
      awaited_responses.push_back(want);
    end else begin
      awaited_responses.push_back(arbitrate(kind, id, age));
    end
  endtask

  // Write a register with the block idle: no request offered, nothing outstanding.
  task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = index;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (index)
      REG_STREAK_LIMIT:  limit_reg     = value;
      REG_AGE_THRESHOLD: threshold_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic mix_traffic(input int count, input int add_pct);
    repeat (count) begin
      send_request(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_SERVE,
                   ID_W'($urandom), AGE_W'($urandom));
    end
  endtask

  // Response side: stall on a pattern that changes mode now and then, and hold
  // off completely while a pressure stretch is counting down.
  initial begin
    int mode;
    int mode_left;
    rsp_ch.ready = 1'b0;
    mode_left    = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        rsp_ch.ready = 1'b0;
        hold_off--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready = 1'b1;
          1: rsp_ch.ready = 1'($urandom_range(0, 1));
          2: rsp_ch.ready = ~rsp_ch.ready;
          default: rsp_ch.ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Compare every accepted response, field by field, with the oldest one awaited.
  initial begin
    outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          report("unrequested response status", 32'(rsp_ch.status), 32'hffffffff);
        end else begin
          want = awaited_responses.pop_front();
          if (rsp_ch.status !== want.status)
            report("status", 32'(rsp_ch.status), 32'(want.status));
          if (rsp_ch.served_id !== want.id)
            report("served_id", 32'(rsp_ch.served_id), 32'(want.id));
          if (rsp_ch.served_age !== want.age)
            report("served_age", 32'(rsp_ch.served_age), 32'(want.age));
          if (rsp_ch.served_class !== want.cls)
            report("served_class", 32'(rsp_ch.served_class), 32'(want.cls));
        end
      end
    end
  end

  // Stimulus: directed plan, mixed traffic over several settings, a pressure
  // stretch, the priority line filled past capacity, then a long streak that
  // wraps through zero after the limit is lowered under it.
  initial begin
    int   room;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_ADD;
    req_ch.person_id = '0;
    req_ch.age       = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_STREAK_LIMIT;
    cfg_ch.data      = '0;
    burst_left       = 0;
    hold_off         = 0;
    mismatch_count   = 0;
    streak           = '0;
    limit_reg        = STREAK_LIMIT_RESET;
    threshold_reg    = AGE_THRESHOLD_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].op == ROW_REGISTER) begin
        set_register(PLAN[i].reg_index, PLAN[i].reg_value);
      end else begin
        send_request(PLAN[i].kind, PLAN[i].id, PLAN[i].age, PLAN[i].typed, PLAN[i].want);
      end
    end

    // Mixed traffic over a spread of settings, threshold extremes among them.
    set_register(REG_STREAK_LIMIT, 8'd2);
    set_register(REG_AGE_THRESHOLD, 8'd60);
    mix_traffic(20, 55);
    set_register(REG_STREAK_LIMIT, 8'd0);
    set_register(REG_AGE_THRESHOLD, 8'd0);
    mix_traffic(20, 55);
    set_register(REG_STREAK_LIMIT, 8'd4);
    set_register(REG_AGE_THRESHOLD, 8'd200);
    mix_traffic(20, 50);
    set_register(REG_STREAK_LIMIT, 8'd1);
    set_register(REG_AGE_THRESHOLD, 8'd255);
    mix_traffic(20, 50);
    set_register(REG_STREAK_LIMIT, CFG_DATA_W'($urandom_range(0, 6)));
    set_register(REG_AGE_THRESHOLD, CFG_DATA_W'($urandom));
    mix_traffic(20, 55);

    // Pressure: hold the response side off while requests keep coming, so the
    // block backs up and stalls its request side.
    @(posedge clk);
    hold_off = 300;
    mix_traffic(40, 70);

    // Leave a few ordinary entries waiting, then fill the priority line to
    // capacity and keep adding to it.
    set_register(REG_STREAK_LIMIT, 8'd255);
    set_register(REG_AGE_THRESHOLD, 8'd100);
    repeat (4) send_request(KIND_ADD, ID_W'($urandom), AGE_W'($urandom_range(0, 100)));
    room = QUEUE_DEPTH - priority_line.size();
    repeat (room + 8) begin
      send_request(KIND_ADD, ID_W'($urandom), AGE_W'($urandom_range(101, 255)));
    end

    // Long streak at the top limit, then drop the limit under the streak so it
    // has to wrap through zero before an ordinary entry gets a turn.
    repeat (200) send_request(KIND_SERVE, ID_W'($urandom), AGE_W'($urandom));
    set_register(REG_STREAK_LIMIT, 8'd3);
    repeat (60) send_request(KIND_SERVE, ID_W'($urandom), AGE_W'($urandom));
    mix_traffic(20, 30);

    // Drain: wait for every response, then a few quiet cycles for strays.
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[two_class_fifo_weighted_arbiter_core] OK");
    end else begin
      $display("[two_class_fifo_weighted_arbiter_core] ERROR");
    end
    $finish;
  end

endmodule
